// File: rtl/fcgm_pkg.sv
// Package for the false-color gradient map block.
// Holds the mode codes, hue sextant codes and channel widths.
// No dependencies.
`timescale 1ns / 1ps

package fcgm_pkg;

  localparam int unsigned MODE_BITS = 3;
  localparam int unsigned CH_BITS   = 8;
  localparam int unsigned SEXT_BITS = 3;
  // Quotient bits of one channel scale (floor of 255 * num / den, num <= den)
  localparam int unsigned SCALE_STEPS = CH_BITS;

  localparam logic [MODE_BITS-1:0] MODE_GREY  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_JET   = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_HOT   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_HSV   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_SHSV  = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_BLACK = 3'd5;

  // Hue wheel sextants
  localparam logic [SEXT_BITS-1:0] SEXT_RED_YEL   = 3'd0;
  localparam logic [SEXT_BITS-1:0] SEXT_YEL_GRN   = 3'd1;
  localparam logic [SEXT_BITS-1:0] SEXT_GRN_CYAN  = 3'd2;
  localparam logic [SEXT_BITS-1:0] SEXT_CYAN_BLUE = 3'd3;
  localparam logic [SEXT_BITS-1:0] SEXT_BLUE_MAG  = 3'd4;

  localparam logic [CH_BITS-1:0] CH_FULL = 8'hFF;

endpackage

// File: rtl/fcgm_cell.sv
// One restoring-division cell of the false-color gradient map chain.
// Shifts one dividend bit into each lane remainder; uses fcgm_pkg.
`timescale 1ns / 1ps

module fcgm_cell import fcgm_pkg::*; #(
  parameter int unsigned W     = 16,
  parameter int unsigned SW    = 8,
  parameter int unsigned LANES = 1,
  parameter int unsigned PW    = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [W-1:0]                 den_i,
  input  logic [LANES-1:0][W-1:0]      rem_i,
  input  logic [LANES-1:0][SW-1:0]     sh_i,
  input  logic [PW-1:0]                pass_i,
  output logic                         valid_o,
  output logic [W-1:0]                 den_o,
  output logic [LANES-1:0][W-1:0]      rem_o,
  output logic [LANES-1:0][SW-1:0]     sh_o,
  output logic [PW-1:0]                pass_o
);

  logic                     valid_q;
  logic [W-1:0]             den_q;
  logic [LANES-1:0][W-1:0]  rem_d, rem_q;
  logic [LANES-1:0][SW-1:0] sh_d, sh_q;
  logic [PW-1:0]            pass_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [W:0] trial;
    logic       ge;
    assign trial = {rem_i[l], sh_i[l][SW-1]};
    assign ge    = (trial >= {1'b0, den_i});
    // Subtract when the trial remainder reaches the divisor; the bit becomes a quotient bit
    assign rem_d[l] = ge ? W'(trial - {1'b0, den_i}) : trial[W-1:0];
    assign sh_d[l]  = {sh_i[l][SW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= den_i;
      rem_q  <= rem_d;
      sh_q   <= sh_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign sh_o    = sh_q;
  assign pass_o  = pass_q;

endmodule

// File: rtl/fcgm_select.sv
// Gradient segment selection for the false-color gradient map.
// Turns position, sextant and mode into per-channel dividends; uses fcgm_pkg.
`timescale 1ns / 1ps

module fcgm_select import fcgm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [MODE_BITS-1:0]                 mode_i,
  input  logic [COUNT_BITS-1:0]                pos_i,
  input  logic [COUNT_BITS-1:0]                count_i,
  input  logic [COUNT_BITS-1:0]                frac_i,
  input  logic [SEXT_BITS-1:0]                 sext_i,
  output logic                                 valid_o,
  output logic [COUNT_BITS:0]                  den_o,
  output logic [2:0][COUNT_BITS:0]             rem_o,
  output logic [2:0][CH_BITS-1:0]              sh_o,
  output logic                                 white_o
);

  localparam int unsigned WN = COUNT_BITS + 4;
  localparam int unsigned NW = COUNT_BITS + 1;
  localparam int unsigned DW = NW + CH_BITS;

  logic [WN-1:0] n, n3, n5, n7, n9, s, s3, s8, fn;
  logic [NW-1:0] num_r, num_g, num_b, den;
  logic          white;
  logic [2:0][NW-1:0] num;
  logic [2:0][NW-1:0] rem_d;
  logic [2:0][CH_BITS-1:0] sh_d;
  logic          valid_q, white_q;
  logic [NW-1:0] den_q;
  logic [2:0][NW-1:0] rem_q;
  logic [2:0][CH_BITS-1:0] sh_q;

  assign n  = WN'(count_i);
  assign s  = WN'(pos_i);
  assign fn = WN'(frac_i);
  assign n3 = (n << 1) + n;
  assign n5 = (n << 2) + n;
  assign n7 = (n << 3) - n;
  assign n9 = (n << 3) + n;
  assign s3 = (s << 1) + s;
  assign s8 = s << 3;

  always_comb begin
    num_r = '0;
    num_g = '0;
    num_b = '0;
    den   = NW'(n);
    white = 1'b0;
    unique case (mode_i) inside
      MODE_GREY: begin
        num_r = NW'(s);
        num_g = NW'(s);
        num_b = NW'(s);
      end
      MODE_JET: begin
        den = NW'(n << 1);
        if (s8 <= n) begin
          num_b = NW'(n + s8);
        end else if (s8 < n3) begin
          num_g = NW'(s8 - n);
          num_b = den;
        end else if (s8 < n5) begin
          num_r = NW'(s8 - n3);
          num_g = den;
          num_b = NW'(n5 - s8);
        end else if (s8 < n7) begin
          num_r = den;
          num_g = NW'(n7 - s8);
        end else begin
          num_r = NW'(n9 - s8);
        end
      end
      MODE_HOT: begin
        if (s3 <= n) begin
          num_r = NW'(s3);
        end else if (s3 <= (n << 1)) begin
          num_r = den;
          num_g = NW'(s3 - n);
        end else begin
          num_r = den;
          num_g = den;
          num_b = NW'(s3 - (n << 1));
        end
      end
      MODE_HSV, MODE_SHSV: begin
        unique case (sext_i)
          SEXT_RED_YEL: begin
            num_r = den;
            num_g = NW'(fn);
          end
          SEXT_YEL_GRN: begin
            num_r = NW'(n - fn);
            num_g = den;
          end
          SEXT_GRN_CYAN: begin
            num_g = den;
            num_b = NW'(fn);
          end
          SEXT_CYAN_BLUE: begin
            num_g = NW'(n - fn);
            num_b = den;
          end
          SEXT_BLUE_MAG: begin
            num_r = NW'(fn);
            num_b = den;
          end
          default: begin
            num_r = den;
            num_b = NW'(n - fn);
          end
        endcase
      end
      MODE_BLACK: begin
        white = 1'b0;
      end
      default: begin
        white = 1'b1;
      end
    endcase
  end

  assign num = {num_b, num_g, num_r};

  for (genvar l = 0; l < 3; l++) begin : g_div
    logic [DW-1:0] prod;
    // Multiply by 255 as a shift and subtract
    assign prod     = {num[l], {CH_BITS{1'b0}}} - DW'(num[l]);
    assign rem_d[l] = prod[DW-1:CH_BITS];
    assign sh_d[l]  = prod[CH_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q   <= den;
      rem_q   <= rem_d;
      sh_q    <= sh_d;
      white_q <= white;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign sh_o    = sh_q;
  assign white_o = white_q;

endmodule

// File: rtl/false_color_gradient_map_core.sv
// Top level of the false-color gradient map: input skid, division cell chains,
// segment selection and output register. Uses fcgm_pkg, fcgm_cell, fcgm_select.
//
// Usage:
//   Slave stream carries bucket_index in tdata and the gradient mode in tuser.
//   Master stream returns one RGB color per transfer: red, green, blue bytes.
//   cfg_we_i/cfg_wdata_i write the bucket count (zero acts as one); write only
//   while no transfer is in flight.
// Path from input transfer to output valid:
//   INDEX_BITS cells reduce the index modulo the count one bit a cycle, three
//   cells find the hue sextant, one stage selects the segment, eight cells
//   form floor(255 * num / den) for all three channels, one output register.
// Throughput: one transfer per cycle; every cell advances every cycle unless the receiver stalls.
// Reset clears all valid bits and loads a bucket count of 256.
// When the receiver stalls the whole chain holds; an input skid register
//   takes one more transfer, so tready on the slave side is a register.
`timescale 1ns / 1ps

module false_color_gradient_map_core import fcgm_pkg::*; #(
  parameter int unsigned INDEX_BITS = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [COUNT_BITS-1:0]               cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // bucket_index, zero padded to whole bytes
  input  logic [((INDEX_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // mode
  input  logic [MODE_BITS-1:0]                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [3*CH_BITS-1:0]                m_axis_tdata
);

  localparam int unsigned NW = COUNT_BITS + 1;
  localparam int unsigned SW6 = COUNT_BITS + 3;

  logic [COUNT_BITS-1:0] count_q, count_eff;
  logic                  en;

  // Bucket count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_BITS'(256);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign count_eff = (count_q == '0) ? COUNT_BITS'(1) : count_q;

  // Advance the chain unless a finished color is waiting
  assign en = !(m_axis_tvalid && !m_axis_tready);

  // Input skid register
  logic                  skid_valid_q;
  logic [INDEX_BITS-1:0] skid_idx_q;
  logic [MODE_BITS-1:0]  skid_mode_q;
  logic                  in_xfer, entry_valid;
  logic [INDEX_BITS-1:0] entry_idx;
  logic [MODE_BITS-1:0]  entry_mode;

  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign entry_valid   = skid_valid_q || in_xfer;
  assign entry_idx     = skid_valid_q ? skid_idx_q : s_axis_tdata[INDEX_BITS-1:0];
  assign entry_mode    = skid_valid_q ? skid_mode_q : s_axis_tuser;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en) begin
      skid_valid_q <= 1'b0;
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Hold a transfer that arrives during a stall
  always_ff @(posedge clk_i) begin
    if (!en && in_xfer) begin
      skid_idx_q  <= s_axis_tdata[INDEX_BITS-1:0];
      skid_mode_q <= s_axis_tuser;
    end
  end

  // Modulo chain: one index bit per cell
  logic                        md_valid [INDEX_BITS+1];
  logic [COUNT_BITS-1:0]       md_den   [INDEX_BITS+1];
  logic [0:0][COUNT_BITS-1:0]  md_rem   [INDEX_BITS+1];
  logic [0:0][INDEX_BITS-1:0]  md_sh    [INDEX_BITS+1];
  logic [MODE_BITS-1:0]        md_mode  [INDEX_BITS+1];

  assign md_valid[0] = entry_valid;
  assign md_den[0]   = count_eff;
  assign md_rem[0]   = '0;
  assign md_sh[0]    = entry_idx;
  assign md_mode[0]  = entry_mode;

  for (genvar i = 0; i < INDEX_BITS; i++) begin : g_mod
    fcgm_cell #(
      .W(COUNT_BITS), .SW(INDEX_BITS), .LANES(1), .PW(MODE_BITS)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(md_valid[i]), .den_i(md_den[i]), .rem_i(md_rem[i]),
      .sh_i(md_sh[i]), .pass_i(md_mode[i]),
      .valid_o(md_valid[i+1]), .den_o(md_den[i+1]), .rem_o(md_rem[i+1]),
      .sh_o(md_sh[i+1]), .pass_o(md_mode[i+1])
    );
  end

  // Sextant chain: divide 6s by the count, three quotient bits
  localparam int unsigned KP = MODE_BITS + COUNT_BITS;

  logic [SW6-1:0]                 pos6;
  logic                           kd_valid [SEXT_BITS+1];
  logic [COUNT_BITS-1:0]          kd_den   [SEXT_BITS+1];
  logic [0:0][COUNT_BITS-1:0]     kd_rem   [SEXT_BITS+1];
  logic [0:0][SEXT_BITS-1:0]      kd_sh    [SEXT_BITS+1];
  logic [KP-1:0]                  kd_pass  [SEXT_BITS+1];

  assign pos6        = (SW6'(md_rem[INDEX_BITS][0]) << 2) + (SW6'(md_rem[INDEX_BITS][0]) << 1);
  assign kd_valid[0] = md_valid[INDEX_BITS];
  assign kd_den[0]   = md_den[INDEX_BITS];
  assign kd_rem[0]   = pos6[SW6-1:SEXT_BITS];
  assign kd_sh[0]    = pos6[SEXT_BITS-1:0];
  assign kd_pass[0]  = {md_mode[INDEX_BITS], md_rem[INDEX_BITS][0]};

  for (genvar i = 0; i < SEXT_BITS; i++) begin : g_sext
    fcgm_cell #(
      .W(COUNT_BITS), .SW(SEXT_BITS), .LANES(1), .PW(KP)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(kd_valid[i]), .den_i(kd_den[i]), .rem_i(kd_rem[i]),
      .sh_i(kd_sh[i]), .pass_i(kd_pass[i]),
      .valid_o(kd_valid[i+1]), .den_o(kd_den[i+1]), .rem_o(kd_rem[i+1]),
      .sh_o(kd_sh[i+1]), .pass_o(kd_pass[i+1])
    );
  end

  // Segment selection
  logic                       sc_valid [SCALE_STEPS+1];
  logic [NW-1:0]              sc_den   [SCALE_STEPS+1];
  logic [2:0][NW-1:0]         sc_rem   [SCALE_STEPS+1];
  logic [2:0][CH_BITS-1:0]    sc_sh    [SCALE_STEPS+1];
  logic [0:0]                 sc_white [SCALE_STEPS+1];

  fcgm_select #(.COUNT_BITS(COUNT_BITS)) u_select (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(kd_valid[SEXT_BITS]),
    .mode_i(kd_pass[SEXT_BITS][KP-1:COUNT_BITS]),
    .pos_i(kd_pass[SEXT_BITS][COUNT_BITS-1:0]),
    .count_i(kd_den[SEXT_BITS]),
    .frac_i(kd_rem[SEXT_BITS][0]),
    .sext_i(kd_sh[SEXT_BITS][0]),
    .valid_o(sc_valid[0]), .den_o(sc_den[0]), .rem_o(sc_rem[0]),
    .sh_o(sc_sh[0]), .white_o(sc_white[0][0])
  );

  // Scale chain: eight quotient bits for each channel
  for (genvar i = 0; i < SCALE_STEPS; i++) begin : g_scale
    fcgm_cell #(
      .W(NW), .SW(CH_BITS), .LANES(3), .PW(1)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sc_valid[i]), .den_i(sc_den[i]), .rem_i(sc_rem[i]),
      .sh_i(sc_sh[i]), .pass_i(sc_white[i]),
      .valid_o(sc_valid[i+1]), .den_o(sc_den[i+1]), .rem_o(sc_rem[i+1]),
      .sh_o(sc_sh[i+1]), .pass_o(sc_white[i+1])
    );
  end

  // Output register
  logic                 out_valid_q;
  logic [3*CH_BITS-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sc_valid[SCALE_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= sc_white[SCALE_STEPS][0] ? {3{CH_FULL}} : sc_sh[SCALE_STEPS];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: tb/tb_top.sv
// Testbench for false_color_gradient_map_core: random and directed colormap lookups
// checked against a behavioral color predictor. Depends on fcgm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import fcgm_pkg::*;

  localparam int unsigned IDX_W = 32;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned LATENCY = IDX_W + 13;

  typedef struct packed {
    logic [IDX_W-1:0]     bucket_index;
    logic [MODE_BITS-1:0] mode;
  } lookup_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IDX_W-1:0] s_axis_tdata = '0;      // bucket_index
  logic [MODE_BITS-1:0] s_axis_tuser = '0;  // mode
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [3*CH_BITS-1:0] m_axis_tdata;       // red, green, blue from bit 0 up

  false_color_gradient_map_core #(.INDEX_BITS(IDX_W), .COUNT_BITS(CNT_W)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  lookup_t pending_lookups[$];
  rgb_t    expected_colors[$];
  logic [CNT_W-1:0] bucket_count_model = 16'd256;
  int errors = 0;
  bit hold_sender = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;

  // Short gaps mostly, an occasional long one, sometimes long stretches of none.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] scale_255(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (num * 255) / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic rgb_t color_for(lookup_t lk, logic [CNT_W-1:0] cnt);
    longint unsigned n, s, n2, s8, s3, k, fn;
    logic [7:0] up, down;
    rgb_t c;
    n = (cnt == 0) ? 1 : cnt;
    s = lk.bucket_index % n;
    n2 = 2 * n;
    c = '0;
    case (lk.mode) inside
      MODE_GREY: begin
        c.red = scale_255(s, n); c.green = c.red; c.blue = c.red;
      end
      MODE_JET: begin
        s8 = 8 * s;
        if (s8 <= n) c.blue = scale_255(n + s8, n2);
        else if (s8 < 3 * n) begin
          c.green = scale_255(s8 - n, n2); c.blue = 8'hFF;
        end else if (s8 < 5 * n) begin
          c.red = scale_255(s8 - 3 * n, n2); c.green = 8'hFF;
          c.blue = scale_255(5 * n - s8, n2);
        end else if (s8 < 7 * n) begin
          c.red = 8'hFF; c.green = scale_255(7 * n - s8, n2);
        end else c.red = scale_255(9 * n - s8, n2);
      end
      MODE_HOT: begin
        s3 = 3 * s;
        if (s3 <= n) c.red = scale_255(s3, n);
        else if (s3 <= 2 * n) begin
          c.red = 8'hFF; c.green = scale_255(s3 - n, n);
        end else begin
          c.red = 8'hFF; c.green = 8'hFF; c.blue = scale_255(s3 - 2 * n, n);
        end
      end
      MODE_HSV, MODE_SHSV: begin
        k = (6 * s) / n;
        fn = 6 * s - k * n;
        up = scale_255(fn, n);
        down = scale_255(n - fn, n);
        case (k)
          SEXT_RED_YEL:   c = '{blue: 8'h00, green: up,    red: 8'hFF};
          SEXT_YEL_GRN:   c = '{blue: 8'h00, green: 8'hFF, red: down};
          SEXT_GRN_CYAN:  c = '{blue: up,    green: 8'hFF, red: 8'h00};
          SEXT_CYAN_BLUE: c = '{blue: 8'hFF, green: down,  red: 8'h00};
          SEXT_BLUE_MAG:  c = '{blue: 8'hFF, green: 8'h00, red: up};
          default:        c = '{blue: down,  green: 8'h00, red: 8'hFF};
        endcase
      end
      MODE_BLACK: c = '0;
      default: c = '1;
    endcase
    return c;
  endfunction

  // Driver: advance to the next pending lookup after each transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_colors.push_back(color_for(lookup_t'{s_axis_tdata, s_axis_tuser},
                                            bucket_count_model));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0 || hold_sender || pending_lookups.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (src_gap > 0) src_gap <= src_gap - 1;
        end else begin
          lookup_t lk;
          lk = pending_lookups.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= lk.bucket_index;
          s_axis_tuser <= lk.mode;
          src_gap <= pick_gap();
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expected color.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected color %h", $time, m_axis_tdata);
          errors++;
        end else begin
          rgb_t want, got;
          want = expected_colors.pop_front();
          got = m_axis_tdata;
          if (got.red !== want.red) begin
            $display("%0t: red expected %h actual %h", $time, want.red, got.red);
            errors++;
          end
          if (got.green !== want.green) begin
            $display("%0t: green expected %h actual %h", $time, want.green, got.green);
            errors++;
          end
          if (got.blue !== want.blue) begin
            $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
            errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        m_axis_tready <= 1'b0;
        snk_gap <= snk_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) snk_gap <= pick_gap();
      end
    end
  end

  task automatic queue_lookup(input logic [IDX_W-1:0] idx, input logic [MODE_BITS-1:0] md);
    pending_lookups.push_back(lookup_t'{idx, md});
  endtask

  // Hold until every queued lookup has produced its color, then let the pipe drain.
  task automatic drain();
    while (pending_lookups.size() != 0 || s_axis_tvalid || expected_colors.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] cnt);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cnt;
    bucket_count_model = cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int items);
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 3))
        0: idx = $urandom();
        1: idx = IDX_W'($urandom_range(0, 70000));
        2: idx = IDX_W'(bucket_count_model * $urandom_range(0, 8) + $urandom_range(0, 2) - 1);
        default: idx = {$urandom()} | 32'h8000_0000;
      endcase
      queue_lookup(idx, MODE_BITS'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    logic [CNT_W-1:0] counts[6];
    counts = '{16'd1, 16'hFFFF, 16'd0, 16'd7, 16'd1000, 16'd48};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: reset count, every mode, segment edges, index extremes.
    for (int m = 0; m < 8; m++) queue_lookup(32'd0, MODE_BITS'(m));
    for (int m = 0; m < 8; m++) queue_lookup(32'hFFFF_FFFF, MODE_BITS'(m));
    queue_lookup(32'd32, MODE_JET);
    queue_lookup(32'd96, MODE_JET);
    queue_lookup(32'd224, MODE_JET);
    queue_lookup(32'd255, MODE_JET);
    queue_lookup(32'd86, MODE_HOT);
    queue_lookup(32'd171, MODE_HOT);
    queue_lookup(32'd43, MODE_HSV);
    queue_lookup(32'd213, MODE_SHSV);
    drain();
    random_phase(90);
    // Pause the sender until the pipe is empty.
    hold_sender = 1'b1;
    while (expected_colors.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    hold_sender = 1'b0;
    drain();
    foreach (counts[i]) begin
      write_count(counts[i]);
      queue_lookup(32'hFFFF_FFFF, MODE_JET);
      queue_lookup(32'd0, MODE_HSV);
      random_phase(65);
      drain();
    end
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
